FILE: rtl/core/ppcbtr_pkg.sv
`default_nettype none

package ppcbtr_pkg;

    // Opcodes carried on the input tuser
    localparam logic [3:0] OP_OTHER = 4'd0;
    localparam logic [3:0] OP_B     = 4'd1;
    localparam logic [3:0] OP_BC    = 4'd2;
    localparam logic [3:0] OP_BCCTR = 4'd3;
    localparam logic [3:0] OP_BCLR  = 4'd4;
    localparam logic [3:0] OP_RFI   = 4'd5;
    localparam logic [3:0] OP_SC    = 4'd6;
    localparam logic [3:0] OP_TD    = 4'd7;
    localparam logic [3:0] OP_TDI   = 4'd8;
    localparam logic [3:0] OP_TW    = 4'd9;
    localparam logic [3:0] OP_TWI   = 4'd10;

    // Transfer kinds
    localparam logic [2:0] KIND_ORD     = 3'd0;
    localparam logic [2:0] KIND_JUMP    = 3'd1;
    localparam logic [2:0] KIND_CALL    = 3'd2;
    localparam logic [2:0] KIND_RET     = 3'd3;
    localparam logic [2:0] KIND_SYSCALL = 3'd4;
    localparam logic [2:0] KIND_SYSRET  = 3'd5;

    // Outcome codes
    localparam logic [1:0] OUT_NOT   = 2'd0;
    localparam logic [1:0] OUT_TAKEN = 2'd1;
    localparam logic [1:0] OUT_BACK  = 2'd2;
    localparam logic [1:0] OUT_FWD   = 2'd3;

    // BO bits
    localparam logic [4:0] BO_IGNORE_CR = 5'h10;
    localparam logic [4:0] BO_WANT_CR   = 5'h08;
    localparam logic [4:0] BO_NO_DEC    = 5'h04;
    localparam logic [4:0] BO_WANT_ZERO = 5'h02;

    // TO flag bits
    localparam logic [4:0] FLAG_LT  = 5'h10;
    localparam logic [4:0] FLAG_GT  = 5'h08;
    localparam logic [4:0] FLAG_EQ  = 5'h04;
    localparam logic [4:0] FLAG_LTU = 5'h02;
    localparam logic [4:0] FLAG_GTU = 5'h01;

    localparam int IN_DATA_W  = 304;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_USER_W = 3;

    typedef struct packed {
        logic [3:0]  op;
        logic        link;
        logic [4:0]  cond_field;
        logic [4:0]  cr_bit_index;
        logic [31:0] target;
        logic        target_relative;
        logic [31:0] insn_addr;
        logic [63:0] ctr;
        logic [31:0] cr;
        logic        mode_64;
        logic [63:0] trap_a;
        logic [63:0] trap_b;
    } t_item;

    typedef struct packed {
        logic       conditional;
        logic [1:0] outcome;
    } t_br_res;

    typedef struct packed {
        logic [2:0] kind;
        logic       conditional;
        logic [1:0] outcome;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/ppcbtr_branch.sv
`default_nettype none

// BO evaluation and direction for b, bc, bcctr and bclr
module ppcbtr_branch (
    input  wire ppcbtr_pkg::t_item   i_item,
    output ppcbtr_pkg::t_br_res      o_res
);

    logic [31:0] w_dest;
    logic        w_crbit;
    logic        w_zero;
    logic        w_ok;
    logic        w_ignore_cr;
    logic        w_no_dec;
    logic [1:0]  w_dir;

    always_comb begin
        case (i_item.op)
            ppcbtr_pkg::OP_BCCTR: w_dest = i_item.ctr[31:0];
            ppcbtr_pkg::OP_BCLR:  w_dest = i_item.target;
            default: begin
                w_dest = i_item.target_relative ? (i_item.target + i_item.insn_addr)
                                                : i_item.target;
            end
        endcase
    end

    assign w_dir = (w_dest < i_item.insn_addr) ? ppcbtr_pkg::OUT_BACK : ppcbtr_pkg::OUT_FWD;

    // BI counts from the most significant CR bit
    assign w_crbit = i_item.cr[5'd31 - i_item.cr_bit_index];

    // CTR of one means the decrement reaches zero
    assign w_zero = (i_item.ctr[31:0] == 32'd1)
                 && (!i_item.mode_64 || (i_item.ctr[63:32] == 32'd0));

    assign w_ignore_cr = |(i_item.cond_field & ppcbtr_pkg::BO_IGNORE_CR);
    assign w_no_dec    = |(i_item.cond_field & ppcbtr_pkg::BO_NO_DEC);

    assign w_ok = (w_no_dec || (w_zero == |(i_item.cond_field & ppcbtr_pkg::BO_WANT_ZERO)))
               && (w_ignore_cr || (w_crbit == |(i_item.cond_field & ppcbtr_pkg::BO_WANT_CR)));

    always_comb begin
        if (i_item.op == ppcbtr_pkg::OP_B) begin
            o_res.conditional = 1'b0;
            o_res.outcome     = w_dir;
        end else begin
            o_res.conditional = !(w_ignore_cr && w_no_dec);
            o_res.outcome     = w_ok ? w_dir : ppcbtr_pkg::OUT_NOT;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ppcbtr_trap.sv
`default_nettype none

// Compare flags for tw, twi, td, tdi, masked with TO
module ppcbtr_trap (
    input  wire ppcbtr_pkg::t_item i_item,
    output logic                   o_hit
);

    logic [63:0] w_a;
    logic [63:0] w_b;
    logic        w_eq;
    logic        w_ltu;
    logic        w_lt;
    logic [4:0]  w_flags;

    always_comb begin
        w_a = i_item.trap_a;
        w_b = i_item.trap_b;
        if (i_item.op inside {ppcbtr_pkg::OP_TW, ppcbtr_pkg::OP_TWI}) begin
            w_a = {{32{i_item.trap_a[31]}}, i_item.trap_a[31:0]};
        end
        if (i_item.op inside {ppcbtr_pkg::OP_TW, ppcbtr_pkg::OP_TWI,
                              ppcbtr_pkg::OP_TDI}) begin
            w_b = {{32{i_item.trap_b[31]}}, i_item.trap_b[31:0]};
        end
    end

    assign w_eq  = (w_a == w_b);
    assign w_ltu = (w_a < w_b);
    assign w_lt  = ($signed(w_a) < $signed(w_b));

    always_comb begin
        if (w_eq) begin
            w_flags = ppcbtr_pkg::FLAG_EQ;
        end else begin
            w_flags = (w_ltu ? ppcbtr_pkg::FLAG_LTU : ppcbtr_pkg::FLAG_GTU)
                    | (w_lt  ? ppcbtr_pkg::FLAG_LT  : ppcbtr_pkg::FLAG_GT);
        end
    end

    assign o_hit = |(w_flags & i_item.cond_field);

endmodule

`default_nettype wire

FILE: rtl/core/ppc_branch_trap_resolver_top.sv
// channel   dir  tdata (low bit up)                                     tuser
// s_axis    in   link, cond_field, cr_bit_index, target,                op
//                target_relative, insn_addr, ctr, cr, mode_64,
//                trap_a, trap_b, zero fill to 304 bits
// m_axis    out  conditional, outcome, zero fill to 8 bits              kind
//
// One item a cycle sustained while m_axis is not stalled; an item passes from the input transfer
// to the output through the input register, evaluation logic and result register.
// The critical path is the 64-bit trap compare or the 32-bit target add and compare.
// Synchronous active-low reset clears both valid flags; payload is not reset.
// An output stall backs up through the input register to s_axis_tready.
`default_nettype none

module ppc_branch_trap_resolver_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // link, cond_field, cr_bit_index, target, target_relative, insn_addr,
    // ctr, cr, mode_64, trap_a, trap_b
    input  wire  [ppcbtr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // op
    input  wire  [ppcbtr_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // conditional, outcome
    output logic [ppcbtr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // kind
    output logic [ppcbtr_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    ppcbtr_pkg::t_item   n_in;
    ppcbtr_pkg::t_item   r_in;
    logic                r_in_valid;
    ppcbtr_pkg::t_result n_out;
    ppcbtr_pkg::t_result r_out;
    logic                r_out_valid;
    logic                w_adv;
    ppcbtr_pkg::t_br_res w_br;
    logic                w_trap_hit;

    assign n_in.op              = s_axis_tuser;
    assign n_in.link            = s_axis_tdata[0];
    assign n_in.cond_field      = s_axis_tdata[5:1];
    assign n_in.cr_bit_index    = s_axis_tdata[10:6];
    assign n_in.target          = s_axis_tdata[42:11];
    assign n_in.target_relative = s_axis_tdata[43];
    assign n_in.insn_addr       = s_axis_tdata[75:44];
    assign n_in.ctr             = s_axis_tdata[139:76];
    assign n_in.cr              = s_axis_tdata[171:140];
    assign n_in.mode_64         = s_axis_tdata[172];
    assign n_in.trap_a          = s_axis_tdata[236:173];
    assign n_in.trap_b          = s_axis_tdata[300:237];

    // result register free, or emptying this cycle
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;

    ppcbtr_branch u_branch (
        .i_item (r_in),
        .o_res  (w_br)
    );

    ppcbtr_trap u_trap (
        .i_item (r_in),
        .o_hit  (w_trap_hit)
    );

    always_comb begin
        n_out.kind        = ppcbtr_pkg::KIND_ORD;
        n_out.conditional = 1'b0;
        n_out.outcome     = ppcbtr_pkg::OUT_TAKEN;
        case (r_in.op)
            ppcbtr_pkg::OP_B, ppcbtr_pkg::OP_BC, ppcbtr_pkg::OP_BCCTR: begin
                n_out.kind        = r_in.link ? ppcbtr_pkg::KIND_CALL : ppcbtr_pkg::KIND_JUMP;
                n_out.conditional = w_br.conditional;
                n_out.outcome     = w_br.outcome;
            end
            ppcbtr_pkg::OP_BCLR: begin
                n_out.kind        = r_in.link ? ppcbtr_pkg::KIND_CALL : ppcbtr_pkg::KIND_RET;
                n_out.conditional = w_br.conditional;
                n_out.outcome     = w_br.outcome;
            end
            ppcbtr_pkg::OP_RFI: begin
                n_out.kind = ppcbtr_pkg::KIND_SYSRET;
            end
            ppcbtr_pkg::OP_SC: begin
                n_out.kind = ppcbtr_pkg::KIND_SYSCALL;
            end
            ppcbtr_pkg::OP_TD, ppcbtr_pkg::OP_TDI, ppcbtr_pkg::OP_TW, ppcbtr_pkg::OP_TWI: begin
                n_out.kind        = ppcbtr_pkg::KIND_SYSRET;
                n_out.conditional = 1'b1;
                n_out.outcome     = w_trap_hit ? ppcbtr_pkg::OUT_TAKEN : ppcbtr_pkg::OUT_NOT;
            end
            default: begin
                n_out.kind = ppcbtr_pkg::KIND_ORD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= n_in;
        end
        if (w_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(ppcbtr_pkg::OUT_DATA_W - 3){1'b0}}, r_out.outcome,
                            r_out.conditional};
    assign m_axis_tuser  = r_out.kind;

    a_in_to_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_in_valid)
        else $error("accepted item did not reach the input register");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.kind <= ppcbtr_pkg::KIND_SYSRET)
        else $error("result kind out of range");

    a_uncond_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.conditional |-> r_out.outcome != ppcbtr_pkg::OUT_NOT)
        else $error("unconditional transfer reported as not taken");

    a_trap_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == ppcbtr_pkg::KIND_SYSRET && r_out.conditional
        |-> r_out.outcome == ppcbtr_pkg::OUT_NOT || r_out.outcome == ppcbtr_pkg::OUT_TAKEN)
        else $error("trap result carries a branch direction");

endmodule

`default_nettype wire
